[src/dq_pkg.sv]
// Shared types and constants for the double-ended queue.
`default_nettype none

package dq_pkg;

    localparam int DQ_DEPTH   = 16;
    localparam int WORD_W     = 32;
    localparam int CAP_W      = 5;
    localparam int CMDQ_DEPTH = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic [1:0] ACT_PUSH_REAR  = 2'd0;
    localparam logic [1:0] ACT_PUSH_FRONT = 2'd1;
    localparam logic [1:0] ACT_POP_FRONT  = 2'd2;
    localparam logic [1:0] ACT_POP_REAR   = 2'd3;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        logic              is_pop;
        logic              at_front;
        logic [WORD_W-1:0] value;
    } t_cmd;

endpackage

`default_nettype wire

[src/dq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[src/dq_front.sv]
// Front end: takes one transfer, decodes the action and holds the command for the queue.
`default_nettype none

module dq_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [1:0]                  i_action,
    input  wire logic [dq_pkg::WORD_W-1:0]   i_push_value,
    input  wire logic                        i_q_full,
    output logic                             o_q_push,
    output dq_pkg::t_cmd                     o_cmd
);
    import dq_pkg::*;

    logic r_valid;
    t_cmd r_cmd;
    logic accept;
    t_cmd dec_cmd;

    always_comb begin
        dec_cmd          = '0;
        dec_cmd.value    = i_push_value;
        unique case (i_action)
            ACT_PUSH_REAR:  begin dec_cmd.is_pop = 1'b0; dec_cmd.at_front = 1'b0; end
            ACT_PUSH_FRONT: begin dec_cmd.is_pop = 1'b0; dec_cmd.at_front = 1'b1; end
            ACT_POP_FRONT:  begin dec_cmd.is_pop = 1'b1; dec_cmd.at_front = 1'b1; end
            ACT_POP_REAR:   begin dec_cmd.is_pop = 1'b1; dec_cmd.at_front = 1'b0; end
            default:        dec_cmd = '0;
        endcase
    end

    // stall only when the held command cannot move on this cycle
    assign busy     = r_valid && i_q_full;
    assign accept   = start && !busy;
    assign o_q_push = r_valid && !i_q_full;
    assign o_cmd    = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_q_push) begin
            r_valid <= 1'b0;
        end
        if (accept) begin
            r_cmd <= dec_cmd;
        end
    end

endmodule

`default_nettype wire

[src/dq_cmdq.sv]
// Short command queue between the front end and the execution back end.
`default_nettype none

module dq_cmdq (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire dq_pkg::t_cmd  i_cmd,
    output logic               o_full,
    output logic               o_avail,
    input  wire logic          i_take,
    output dq_pkg::t_cmd       o_cmd
);
    import dq_pkg::*;

    localparam int QPTR_W = $clog2(CMDQ_DEPTH);
    localparam int QCNT_W = $clog2(CMDQ_DEPTH + 1);

    t_cmd              r_slot [CMDQ_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push;
    logic              do_take;

    assign o_full  = (r_cnt == QCNT_W'(CMDQ_DEPTH));
    assign o_avail = (r_cnt != '0);
    assign o_cmd   = r_slot[r_rp];
    assign do_push = i_push && !o_full;
    assign do_take = i_take && o_avail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == QPTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_take) begin
                r_rp <= (r_rp == QPTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_take) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_take && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (do_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

[src/dq_back.sv]
// Back end: executes queued commands on the ring store and produces the result.
`default_nettype none

module dq_back #(
    parameter int DEPTH = dq_pkg::DQ_DEPTH
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [dq_pkg::CAP_W-1:0]    i_capacity,
    input  wire logic                        i_cmd_avail,
    input  wire dq_pkg::t_cmd                i_cmd,
    output logic                             o_cmd_take,
    output logic                             o_done,
    output logic [dq_pkg::WORD_W-1:0]        o_pop_value,
    output logic [1:0]                       o_status,
    output logic                             o_now_empty,
    output logic                             o_now_full
);
    import dq_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int SUM_W = CNT_W + 1;

    typedef enum logic {S_IDLE, S_READ} t_state;

    t_state            r_state, n_state;
    logic [PTR_W-1:0]  r_head, n_head;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_done, n_done;
    logic [WORD_W-1:0] r_pop_value, n_pop_value;
    t_status           r_status, n_status;
    logic              r_empty, r_full;

    logic [CW-1:0]     cap_ext;
    logic [CNT_W-1:0]  eff_cap;
    logic [SUM_W-1:0]  tail_sum, last_sum;
    logic [PTR_W-1:0]  tail_idx, last_idx, head_dec, head_inc;
    logic              full_now;

    logic              ram_we, ram_re;
    logic [PTR_W-1:0]  ram_waddr, ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    // clamp capacity into 1..DEPTH
    always_comb begin
        cap_ext = CW'(i_capacity);
        if (cap_ext == '0) begin
            eff_cap = CNT_W'(1);
        end else if (cap_ext > CW'(DEPTH)) begin
            eff_cap = CNT_W'(DEPTH);
        end else begin
            eff_cap = CNT_W'(cap_ext);
        end
    end

    // ring arithmetic: the sums stay below twice DEPTH
    always_comb begin
        tail_sum = SUM_W'(r_head) + SUM_W'(r_count);
        last_sum = tail_sum - 1'b1;
        tail_idx = (tail_sum >= SUM_W'(DEPTH)) ? PTR_W'(tail_sum - SUM_W'(DEPTH))
                                               : PTR_W'(tail_sum);
        last_idx = (last_sum >= SUM_W'(DEPTH)) ? PTR_W'(last_sum - SUM_W'(DEPTH))
                                               : PTR_W'(last_sum);
        head_dec = (r_head == '0) ? PTR_W'(DEPTH - 1) : r_head - 1'b1;
        head_inc = (r_head == PTR_W'(DEPTH - 1)) ? '0 : r_head + 1'b1;
    end

    assign full_now = (r_count >= eff_cap);

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_done      = 1'b0;
        n_pop_value = r_pop_value;
        n_status    = r_status;
        o_cmd_take  = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_waddr   = tail_idx;
        ram_raddr   = r_head;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_avail) begin
                    o_cmd_take = 1'b1;
                    if (!i_cmd.is_pop) begin
                        n_done      = 1'b1;
                        n_pop_value = '0;
                        if (full_now) begin
                            n_status = ST_OVERFLOW;
                        end else begin
                            n_status = ST_DONE;
                            ram_we   = 1'b1;
                            n_count  = r_count + 1'b1;
                            if (i_cmd.at_front) begin
                                n_head    = head_dec;
                                ram_waddr = head_dec;
                            end
                        end
                    end else if (r_count == '0) begin
                        n_done      = 1'b1;
                        n_pop_value = '1;
                        n_status    = ST_UNDERFLOW;
                    end else begin
                        // result leaves once the RAM read returns
                        ram_re   = 1'b1;
                        n_status = ST_DONE;
                        n_count  = r_count - 1'b1;
                        n_state  = S_READ;
                        if (i_cmd.at_front) begin
                            n_head = head_inc;
                        end else begin
                            ram_raddr = last_idx;
                        end
                    end
                end
            end
            S_READ: begin
                n_done      = 1'b1;
                n_pop_value = ram_rdata;
                n_state     = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_done  <= n_done;
        end
        r_pop_value <= n_pop_value;
        r_status    <= n_status;
        r_empty     <= (n_count == '0);
        r_full      <= (n_count >= eff_cap);
    end

    dq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_cmd.value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_done      = r_done;
    assign o_pop_value = r_pop_value;
    assign o_status    = r_status;
    assign o_now_empty = r_empty;
    assign o_now_full  = r_full;

endmodule

`default_nettype wire

[src/double_ended_queue.sv]
// A push or a refused action reaches o_done through the front register, command queue
// and back-end result register; a live pop also passes the back-end RAM read.
// Throughput: one push per cycle unless busy; a pop holds the back end for its RAM read.
// The two-entry command queue absorbs pops, so busy rises only when it and the front fill.
// Results are a one-cycle strobe; the receiver cannot stall.
// Synchronous active-low reset empties the queue, clears the head and sets capacity to 16.
`default_nettype none

module double_ended_queue #(
    parameter int DEPTH = dq_pkg::DQ_DEPTH
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [dq_pkg::CAP_W-1:0]    i_cfg_wdata,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [1:0]                  i_action,
    input  wire logic signed [dq_pkg::WORD_W-1:0] i_push_value,
    output logic                             o_done,
    output logic signed [dq_pkg::WORD_W-1:0] o_pop_value,
    output logic [1:0]                       o_status,
    output logic                             o_now_empty,
    output logic                             o_now_full
);
    import dq_pkg::*;

    logic [CAP_W-1:0]  r_capacity;
    logic              q_full, q_push, q_avail, q_take;
    t_cmd              front_cmd, back_cmd;
    logic [WORD_W-1:0] pop_bits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_wdata;
        end
    end

    dq_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_action     (i_action),
        .i_push_value (i_push_value),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_cmd        (front_cmd)
    );

    dq_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .o_avail (q_avail),
        .i_take  (q_take),
        .o_cmd   (back_cmd)
    );

    dq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_capacity  (r_capacity),
        .i_cmd_avail (q_avail),
        .i_cmd       (back_cmd),
        .o_cmd_take  (q_take),
        .o_done      (o_done),
        .o_pop_value (pop_bits),
        .o_status    (o_status),
        .o_now_empty (o_now_empty),
        .o_now_full  (o_now_full)
    );

    assign o_pop_value = signed'(pop_bits);

endmodule

`default_nettype wire

[src/dq_checker.sv]
// Port-level checks for the double-ended queue, bound to the top level.
`default_nettype none

module dq_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_done,
    input wire logic [31:0] o_pop_value,
    input wire logic [1:0]  o_status,
    input wire logic        o_now_empty,
    input wire logic        o_now_full
);
    import dq_pkg::*;

    a_underflow_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_UNDERFLOW) |-> (o_pop_value == '1 && o_now_empty))
        else $error("underflow result must carry -1 and an empty queue");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_OVERFLOW) |-> (o_now_full && o_pop_value == '0))
        else $error("overflow result must show a full queue and zero word");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_now_empty && o_now_full))
        else $error("queue reported empty and full together");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status == ST_DONE || o_status == ST_OVERFLOW ||
                    o_status == ST_UNDERFLOW))
        else $error("result carries an unused status code");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result strobe right after reset");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_done      (o_done),
    .o_pop_value (o_pop_value),
    .o_status    (o_status),
    .o_now_empty (o_now_empty),
    .o_now_full  (o_now_full)
);

`default_nettype wire

[dv/tb.sv]
// Self-checking testbench for the double-ended queue: directed corners, then random traffic.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dq_pkg::*;

    localparam int          CYCLE_LIMIT = 200000;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          IDX_W = $clog2(DQ_DEPTH);
    localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] WORD_MIN = 32'h8000_0000;
    localparam logic [31:0] WORD_ONES = 32'hFFFF_FFFF;

    typedef struct {
        logic signed [WORD_W-1:0] pop_value;
        t_status                  status;
        logic                     now_empty;
        logic                     now_full;
    } t_outcome;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CAP_W-1:0]         i_cfg_wdata = '0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [1:0]               i_action = ACT_PUSH_REAR;
    logic signed [WORD_W-1:0] i_push_value = '0;
    logic                     o_done;
    logic signed [WORD_W-1:0] o_pop_value;
    logic [1:0]               o_status;
    logic                     o_now_empty;
    logic                     o_now_full;

    // Shadow copy of the deque contents and the capacity register
    logic [WORD_W-1:0]          ring_words [DQ_DEPTH];
    logic [IDX_W-1:0]           front_idx;
    logic [CAP_W-1:0]           live_count;
    logic [CAP_W-1:0]           capacity_reg;

    t_outcome    pending_outcomes [$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    double_ended_queue u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .start        (start),
        .busy         (busy),
        .i_action     (i_action),
        .i_push_value (i_push_value),
        .o_done       (o_done),
        .o_pop_value  (o_pop_value),
        .o_status     (o_status),
        .o_now_empty  (o_now_empty),
        .o_now_full   (o_now_full)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $error("timeout after %0d cycles, %0d results outstanding",
                   cycle_count, pending_outcomes.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int unsigned usable_capacity();
        int unsigned c;
        c = 32'(capacity_reg);
        if (c == 0) c = 1;
        if (c > DQ_DEPTH) c = DQ_DEPTH;
        return c;
    endfunction

    // Apply one action to the shadow deque and queue up the result it must produce
    function automatic void apply_deque_action(logic [1:0] act, logic [WORD_W-1:0] word);
        t_outcome    res;
        int unsigned lim;
        lim = usable_capacity();
        res.pop_value = '0;
        res.status = ST_DONE;
        if (act == ACT_PUSH_REAR || act == ACT_PUSH_FRONT) begin
            if (live_count >= lim) begin
                res.status = ST_OVERFLOW;
            end else if (act == ACT_PUSH_REAR) begin
                ring_words[IDX_W'((front_idx + live_count) % DQ_DEPTH)] = word;
                live_count++;
            end else begin
                front_idx = IDX_W'((front_idx + DQ_DEPTH - 1) % DQ_DEPTH);
                ring_words[front_idx] = word;
                live_count++;
            end
        end else begin
            if (live_count == 0) begin
                res.status = ST_UNDERFLOW;
                res.pop_value = WORD_ONES;
            end else if (act == ACT_POP_FRONT) begin
                res.pop_value = ring_words[front_idx];
                front_idx = IDX_W'((front_idx + 1) % DQ_DEPTH);
                live_count--;
            end else begin
                res.pop_value = ring_words[IDX_W'((front_idx + live_count - 1) % DQ_DEPTH)];
                live_count--;
            end
        end
        res.now_empty = (live_count == 0);
        res.now_full = (live_count >= lim);
        pending_outcomes.push_back(res);
    endfunction

    // Compare every strobed result against the oldest prediction
    always @(posedge i_clk) begin
        t_outcome exp_res;
        if (i_rst_n && o_done) begin
            if (pending_outcomes.size() == 0) begin
                $error("unexpected result: pop_value %0d status %0d", o_pop_value, o_status);
                mismatch_count++;
            end else begin
                exp_res = pending_outcomes.pop_front();
                if (o_pop_value !== exp_res.pop_value) begin
                    $error("pop_value mismatch: expected %0d, got %0d",
                           exp_res.pop_value, o_pop_value);
                    mismatch_count++;
                end
                if (o_status !== exp_res.status) begin
                    $error("status mismatch: expected %0d, got %0d", exp_res.status, o_status);
                    mismatch_count++;
                end
                if (o_now_empty !== exp_res.now_empty) begin
                    $error("now_empty mismatch: expected %0b, got %0b",
                           exp_res.now_empty, o_now_empty);
                    mismatch_count++;
                end
                if (o_now_full !== exp_res.now_full) begin
                    $error("now_full mismatch: expected %0b, got %0b",
                           exp_res.now_full, o_now_full);
                    mismatch_count++;
                end
            end
        end
    end

    // Drive one action and hold it until the start transfer completes
    task automatic send_action(input logic [1:0] act, input logic [WORD_W-1:0] word,
                               input int unsigned idle_pct);
        int unsigned gap;
        gap = 0;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) gap = $urandom_range(4, 1);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_action <= act;
        i_push_value <= word;
        do @(posedge i_clk); while (busy);
        apply_deque_action(act, word);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Only called with the block idle
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= cap;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        capacity_reg = cap;
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(15))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return '0;
            3: return WORD_ONES;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_underflow_overflow();
        drain_results();
        write_capacity(CAP_W'(2));
        send_action(ACT_POP_FRONT, 32'h1234_5678, 0);
        send_action(ACT_POP_REAR, WORD_ONES, 0);
        send_action(ACT_PUSH_REAR, WORD_MAX, 0);
        // head wraps below zero here
        send_action(ACT_PUSH_FRONT, WORD_MIN, 0);
        send_action(ACT_PUSH_REAR, 32'hAAAA_AAAA, 0);
        send_action(ACT_PUSH_FRONT, 32'h5555_5555, 0);
        send_action(ACT_POP_REAR, '0, 0);
        send_action(ACT_POP_FRONT, '0, 0);
        send_action(ACT_POP_FRONT, '0, 0);
    endtask

    task automatic test_capacity_shrink();
        drain_results();
        write_capacity(CAP_W'(16));
        send_action(ACT_PUSH_REAR, 32'h0000_0001, 0);
        send_action(ACT_PUSH_FRONT, '0, 0);
        send_action(ACT_PUSH_REAR, WORD_ONES, 0);
        drain_results();
        // drop below the live count: entries stay, pushes are refused
        write_capacity(CAP_W'(1));
        send_action(ACT_PUSH_REAR, 32'hDEAD_BEEF, 0);
        send_action(ACT_POP_FRONT, '0, 0);
        send_action(ACT_POP_REAR, '0, 0);
        send_action(ACT_POP_REAR, '0, 0);
        send_action(ACT_POP_FRONT, '0, 0);
    endtask

    task automatic test_random_traffic(input logic [CAP_W-1:0] cap, input int unsigned n_items,
                                       input int unsigned idle_pct);
        int unsigned push_pct;
        int unsigned seg_idle;
        logic [1:0]  act;
        drain_results();
        write_capacity(cap);
        push_pct = 50;
        seg_idle = idle_pct;
        for (int unsigned i = 0; i < n_items; i++) begin
            // Change the mix every 24 transfers to sweep between empty and full
            if (i % 24 == 0) begin
                case ($urandom_range(2))
                    0: push_pct = 25;
                    1: push_pct = 50;
                    default: push_pct = 75;
                endcase
                seg_idle = ($urandom_range(3) == 0) ? 0 : idle_pct;
            end
            if ($urandom_range(99) < push_pct)
                act = $urandom_range(1) ? ACT_PUSH_FRONT : ACT_PUSH_REAR;
            else
                act = $urandom_range(1) ? ACT_POP_REAR : ACT_POP_FRONT;
            send_action(act, pick_word(), seg_idle);
        end
    endtask

    initial begin
        front_idx = '0;
        live_count = '0;
        capacity_reg = CAP_RESET;
        foreach (ring_words[k]) ring_words[k] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_underflow_overflow();
        test_capacity_shrink();
        test_random_traffic(CAP_W'(16), 300, 0);
        test_random_traffic(CAP_W'(31), 250, 56);
        test_random_traffic(CAP_W'(4), 250, 37);
        test_random_traffic(CAP_W'(0), 150, 56);
        test_random_traffic(CAP_W'(9), 150, 0);
        test_random_traffic(CAP_W'(1), 100, 37);

        drain_results();
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
